// ===== hdl/pfd_pkg.sv =====
package pfd_pkg;

   localparam int DATA_W = 32;
   localparam int COEF_W = 31;
   localparam int SUM_W = 48;
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 34;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int DEN_W = 48;
   localparam int QUOT_W = 32;
   localparam int ADDR_W = 5;

   localparam logic [2:0] REG_PROP_GAIN = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [2:0] REG_TICK_PERIOD = 3'd3;
   localparam logic [2:0] REG_FILTER_COEF = 3'd4;

   localparam logic [31:0] RST_PROP_GAIN = 32'd65536;
   localparam logic [31:0] RST_INTEG_GAIN = 32'd65536;
   localparam logic [31:0] RST_DERIV_GAIN = 32'd65536;
   localparam logic [31:0] RST_TICK_PERIOD = 32'd1073742;
   localparam logic [30:0] RST_FILTER_COEF = 31'd6553600;

   typedef struct packed {
      logic signed [31:0] reference;
      logic signed [31:0] measurement;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] prop_gain;
      logic signed [31:0] integ_gain;
      logic signed [31:0] deriv_gain;
      logic [31:0] tick_period;
      logic [30:0] filter_coef;
   } cfg_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ERR   = 9'b000000010,
      ST_MGO   = 9'b000000100,
      ST_MWAIT = 9'b000001000,
      ST_SUMI  = 9'b000010000,
      ST_DGO   = 9'b000100000,
      ST_DWAIT = 9'b001000000,
      ST_DRV1  = 9'b010000000,
      ST_DRV2  = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      OP_NKD = 3'd0,
      OP_NUM = 3'd1,
      OP_NDT = 3'd2,
      OP_FS  = 3'd3,
      OP_EDT = 3'd4,
      OP_KPE = 3'd5,
      OP_KIS = 3'd6
   } op_type;

   function automatic logic [31:0] mag32(logic [31:0] x);
      return x[31] ? 32'(~x + 32'd1) : x;
   endfunction

endpackage

// ===== hdl/pfd_csr.sv =====
module pfd_csr
   import pfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en = psel & penable & pwrite;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:2])
            REG_PROP_GAIN:   cfg_in.prop_gain = pwdata;
            REG_INTEG_GAIN:  cfg_in.integ_gain = pwdata;
            REG_DERIV_GAIN:  cfg_in.deriv_gain = pwdata;
            REG_TICK_PERIOD: cfg_in.tick_period = pwdata;
            REG_FILTER_COEF: cfg_in.filter_coef = pwdata[30:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_PROP_GAIN:   prdata = cfg_ff.prop_gain;
         REG_INTEG_GAIN:  prdata = cfg_ff.integ_gain;
         REG_DERIV_GAIN:  prdata = cfg_ff.deriv_gain;
         REG_TICK_PERIOD: prdata = cfg_ff.tick_period;
         REG_FILTER_COEF: prdata = {1'b0, cfg_ff.filter_coef};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain <= RST_PROP_GAIN;
         cfg_ff.integ_gain <= RST_INTEG_GAIN;
         cfg_ff.deriv_gain <= RST_DERIV_GAIN;
         cfg_ff.tick_period <= RST_TICK_PERIOD;
         cfg_ff.filter_coef <= RST_FILTER_COEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/pfd_mul.sv =====
module pfd_mul
   import pfd_pkg::*;
#(
   parameter int AW = MUL_A_W,
   parameter int BW = MUL_B_W
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [AW-1:0]   a,
   input  logic [BW-1:0]   b,
   output logic            done,
   output logic [AW+BW-1:0] product
);

   localparam int CNT_W = $clog2(BW + 1);

   logic [AW-1:0]    a_ff, a_in;
   logic [AW-1:0]    acc_ff, acc_in;
   logic [BW-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AW:0]      step_sum;

   assign done = done_ff;
   assign product = {acc_ff, lo_ff};

   // one multiplier bit per cycle, LSB first; product bits shift into lo
   assign step_sum = {1'b0, acc_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(AW + 1){1'b0}});

   always_comb begin
      a_in = a_ff;
      acc_in = acc_ff;
      lo_in = lo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         acc_in = '0;
         lo_in = b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = step_sum[AW:1];
         lo_in = {step_sum[0], lo_ff[BW-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      acc_ff <= acc_in;
      lo_ff <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== hdl/pfd_div.sv =====
module pfd_div
   import pfd_pkg::*;
#(
   parameter int NW = PROD_W,
   parameter int DW = DEN_W,
   parameter int QW = QUOT_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient,
   output logic          overflow
);

   localparam int CNT_W = $clog2(QW + 1);
   localparam int HI_W = NW - QW;

   logic [DW-1:0]    den_ff, den_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      rem2;
   logic             ge;
   logic [DW:0]      diff;

   assign done = done_ff;
   assign quotient = lo_ff;
   assign overflow = ovf_ff;

   assign rem2 = {rem_ff, lo_ff[QW-1]};
   assign ge = rem2 >= {1'b0, den_ff};
   assign diff = rem2 - {1'b0, den_ff};

   always_comb begin
      den_in = den_ff;
      rem_in = rem_ff;
      lo_in = lo_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         den_in = divisor;
         // quotient reaches 2^QW exactly when the upper part is not below the divisor
         ovf_in = dividend[NW-1:QW] >= HI_W'(divisor);
         rem_in = dividend[QW+DW-1:QW];
         lo_in = dividend[QW-1:0];
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : rem2[DW-1:0];
         lo_in = {lo_ff[QW-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      lo_ff <= lo_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== hdl/pid_filtered_derivative_core.sv =====
// Each accepted item runs through the error, seven products on the shared bit-serial
// multiplier, a serial divide, and sums and saturation before its result is loaded.
// A new item is taken only after the previous one has reached the result register;
// the multiplier retires one multiplier bit per cycle.
// The result register frees the input side while a result waits to be taken.
// Synchronous active-high reset: gains, period, coefficient to defaults, history to zero.
module pid_filtered_derivative_core
   import pfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type cfg;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [32:0]        diff_ff, diff_in;
   logic [31:0]        e_ff, e_in;
   logic [32:0]        de_ff, de_in;
   logic [31:0]        last_error_ff, last_error_in;
   logic [SUM_W-1:0]   error_sum_ff, error_sum_in;
   logic [31:0]        slope_ff, slope_in;
   logic [61:0]        nkd_ff, nkd_in;
   logic [PROD_W-1:0]  num_ff, num_in;
   logic [46:0]        ndt_ff, ndt_in;
   logic [PROD_W-1:0]  s_ff, s_in;
   logic [48:0]        inc_ff, inc_in;
   logic [SUM_W-1:0]   newsum_ff, newsum_in;
   logic [63:0]        kpe_ff, kpe_in;
   logic [63:0]        kis_ff, kis_in;
   logic [31:0]        d_ff, d_in;
   logic [64:0]        part_ff, part_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic                mul_start;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic                mul_neg;
   logic                mul_done;
   logic [PROD_W-1:0]   mul_p;
   logic [PROD_W-1:0]   mul_sp;
   logic                div_start;
   logic [PROD_W-1:0]   div_num;
   logic [DEN_W-1:0]    div_den;
   logic                div_done;
   logic [QUOT_W-1:0]   div_q;
   logic                div_ovf;

   logic [31:0]  e_sat;
   logic [33:0]  de2, de2_mag;
   logic [48:0]  t_val;
   logic [47:0]  t_mag;
   logic [47:0]  sum_mag;
   logic [49:0]  sum50;
   logic [65:0]  acc;
   logic [49:0]  sh;
   logic         out_free;

   pfd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   pfd_mul #(.AW(MUL_A_W), .BW(MUL_B_W)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .product(mul_p)
   );

   pfd_div #(.NW(PROD_W), .DW(DEN_W), .QW(QUOT_W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .done    (div_done),
      .quotient(div_q),
      .overflow(div_ovf)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign e_sat = (diff_ff[32] != diff_ff[31]) ?
                  (diff_ff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : diff_ff[31:0];
   assign de2 = {de_ff, 1'b0};
   assign de2_mag = de2[33] ? 34'(~de2 + 34'd1) : de2;
   assign t_val = {2'b00, ndt_ff} - 49'd8589934592;
   assign t_mag = t_val[48] ? 48'(~t_val + 49'd1) : t_val[47:0];
   assign sum_mag = newsum_ff[47] ? 48'(~newsum_ff + 48'd1) : newsum_ff;
   assign mul_sp = neg_ff ? 98'(~mul_p + 98'd1) : mul_p;
   assign sum50 = {{2{error_sum_ff[47]}}, error_sum_ff} + {inc_ff[48], inc_ff};
   assign acc = {part_ff[64], part_ff} + {{18{d_ff[31]}}, d_ff, 16'h0000};
   assign sh = acc[65:16];

   assign mul_start = (state_ff == ST_MGO);
   assign div_start = (state_ff == ST_DGO);
   assign div_num = s_ff[97] ? 98'(~s_ff + 98'd1) : s_ff;
   assign div_den = 48'({1'b0, ndt_ff}) + 48'd8589934592;

   // operand magnitudes for the current product; signs are applied afterwards
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_neg = 1'b0;
      case (op_ff)
         OP_NKD: begin
            mul_a = 64'(cfg.filter_coef);
            mul_b = 34'(mag32(cfg.deriv_gain));
         end
         OP_NUM: begin
            mul_a = 64'(nkd_ff);
            mul_b = de2_mag;
            mul_neg = cfg.deriv_gain[31] ^ de2[33];
         end
         OP_NDT: begin
            mul_a = 64'(cfg.filter_coef);
            mul_b = 34'(cfg.tick_period);
         end
         OP_FS: begin
            mul_a = 64'(t_mag);
            mul_b = 34'(mag32(slope_ff));
            mul_neg = t_val[48] ^ slope_ff[31];
         end
         OP_EDT: begin
            mul_a = 64'(mag32(e_ff));
            mul_b = 34'(cfg.tick_period);
            mul_neg = e_ff[31];
         end
         OP_KPE: begin
            mul_a = 64'(mag32(e_ff));
            mul_b = 34'(mag32(cfg.prop_gain));
            mul_neg = e_ff[31] ^ cfg.prop_gain[31];
         end
         OP_KIS: begin
            mul_a = 64'(sum_mag);
            mul_b = 34'(mag32(cfg.integ_gain));
            mul_neg = newsum_ff[47] ^ cfg.integ_gain[31];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            mul_neg = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      diff_in = diff_ff;
      e_in = e_ff;
      de_in = de_ff;
      last_error_in = last_error_ff;
      error_sum_in = error_sum_ff;
      slope_in = slope_ff;
      nkd_in = nkd_ff;
      num_in = num_ff;
      ndt_in = ndt_ff;
      s_in = s_ff;
      inc_in = inc_ff;
      newsum_in = newsum_ff;
      kpe_in = kpe_ff;
      kis_in = kis_ff;
      d_in = d_ff;
      part_in = part_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               diff_in = {req_data.reference[31], req_data.reference}
                       - {req_data.measurement[31], req_data.measurement};
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            e_in = e_sat;
            de_in = {e_sat[31], e_sat} - {last_error_ff[31], last_error_ff};
            op_in = OP_NKD;
            state_in = ST_MGO;
         end
         ST_MGO: begin
            neg_in = mul_neg;
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_done) begin
               state_in = ST_MGO;
               case (op_ff)
                  OP_NKD: begin
                     nkd_in = mul_p[61:0];
                     op_in = OP_NUM;
                  end
                  OP_NUM: begin
                     num_in = mul_sp;
                     op_in = OP_NDT;
                  end
                  OP_NDT: begin
                     ndt_in = mul_p[62:16];
                     op_in = OP_FS;
                  end
                  OP_FS: begin
                     s_in = num_ff - mul_sp;
                     op_in = OP_EDT;
                  end
                  OP_EDT: begin
                     // floor shift by 16 of e*dt
                     inc_in = mul_sp[64:16];
                     op_in = OP_KPE;
                     state_in = ST_SUMI;
                  end
                  OP_KPE: begin
                     kpe_in = mul_sp[63:0];
                     op_in = OP_KIS;
                  end
                  OP_KIS: begin
                     kis_in = mul_sp[79:16];
                     state_in = ST_DGO;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SUMI: begin
            if (sum50[49:47] == 3'b000 || sum50[49:47] == 3'b111) begin
               newsum_in = sum50[47:0];
            end else begin
               newsum_in = sum50[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
            end
            state_in = ST_MGO;
         end
         ST_DGO: begin
            neg_in = s_ff[97];
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               if (neg_ff) begin
                  if (div_ovf || (div_q[31] && (|div_q[30:0]))) begin
                     d_in = 32'h8000_0000;
                  end else begin
                     d_in = ~div_q + 32'd1;
                  end
               end else begin
                  d_in = (div_ovf || div_q[31]) ? 32'h7FFF_FFFF : div_q;
               end
               state_in = ST_DRV1;
            end
         end
         ST_DRV1: begin
            part_in = {kpe_ff[63], kpe_ff} + {kis_ff[63], kis_ff};
            state_in = ST_DRV2;
         end
         ST_DRV2: begin
            if (out_free) begin
               if ((&sh[49:31]) || !(|sh[49:31])) begin
                  rsp_in.drive = sh[31:0];
                  rsp_in.clipped = 1'b0;
               end else begin
                  rsp_in.drive = sh[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  rsp_in.clipped = 1'b1;
               end
               rsp_valid_in = 1'b1;
               last_error_in = e_ff;
               error_sum_in = newsum_ff;
               slope_in = d_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      diff_ff <= diff_in;
      e_ff <= e_in;
      de_ff <= de_in;
      nkd_ff <= nkd_in;
      num_ff <= num_in;
      ndt_ff <= ndt_in;
      s_ff <= s_in;
      inc_ff <= inc_in;
      newsum_ff <= newsum_in;
      kpe_ff <= kpe_in;
      kis_ff <= kis_in;
      d_ff <= d_in;
      part_ff <= part_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_error_ff <= '0;
         error_sum_ff <= '0;
         slope_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_error_ff <= last_error_in;
         error_sum_ff <= error_sum_in;
         slope_ff <= slope_in;
      end
   end

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MWAIT)
      else $error("multiplier finished outside its wait state");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DWAIT)
      else $error("divider finished outside its wait state");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRV2 && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not loaded into result register");

endmodule
